// ----- design/dfl_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helpers for the dated rate floor lookup
package dfl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int DATE_W   = 23;
  localparam int RATE_W   = 40;
  localparam int AMOUNT_W = 28;
  localparam int LIMIT_W  = 27;
  localparam int PROD_W   = 51;

  // amount limit after reset, 1000.0 in Q.16
  localparam logic [LIMIT_W-1:0] AMOUNT_LIMIT_RESET = 27'd65536000;

  // reciprocal of 100 scaled by 2^16, rounded down so the quotient never overshoots
  localparam logic [9:0] DIV100_RECIP = 10'd655;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DATE  = 3'd1,
    ST_NEGATIVE  = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_NO_DATA   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // one classified item handed from front to back
  typedef struct packed {
    opcode_t                op;
    status_t                pre_status;
    logic [DATE_W-1:0]      date;
    logic [LIMIT_W-1:0]     amount;
    logic [RATE_W-1:0]      rate;
  } cmd_t;

  // days in a month, for months 1 to 12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- design/dfl_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with registered read
module dfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/dfl_front.sv -----
`timescale 1ns / 1ps
// front end: takes items, checks the date and amount, queues a command
module dfl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic signed [14:0]            in_year,
  input  logic [6:0]                    in_month,
  input  logic [6:0]                    in_day,
  input  logic signed [27:0]            in_amount,
  input  logic [39:0]                   in_entry_rate,
  input  logic                          cfg_valid,
  input  logic [dfl_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                          push,
  output dfl_pkg::cmd_t                 push_cmd,
  input  logic                          q_full
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_EVAL
  } fstate_t;

  fstate_t                        state_r;
  logic                           op_r;
  logic [14:0]                    year_r;
  logic [6:0]                     month_r;
  logic [6:0]                     day_r;
  logic [27:0]                    amount_r;
  logic [39:0]                    rate_r;
  logic [7:0]                     q_r;
  logic [dfl_pkg::LIMIT_W-1:0]    amount_limit_r;

  logic [23:0]                    q_prod;
  logic [13:0]                    q_times;
  logic [13:0]                    diff;
  logic [7:0]                     r_raw;
  logic                           r_ge;
  logic [7:0]                     rem;
  logic [7:0]                     qc;
  logic                           leap;
  logic                           month_ok;
  logic [4:0]                     len;
  logic                           day_ok;
  logic                           date_ok;
  dfl_pkg::status_t               pre_status;

  assign busy = (state_r != F_IDLE);

  // year divided by 100, first estimate (may be one low)
  assign q_prod = 24'(year_r[13:0]) * 24'(dfl_pkg::DIV100_RECIP);

  // remainder by 100 with one correction step
  assign q_times = 14'(14'(q_r) * 14'd100);
  assign diff    = year_r[13:0] - q_times;
  assign r_raw   = diff[7:0];
  assign r_ge    = (r_raw >= 8'd100);
  assign rem     = r_ge ? 8'(r_raw - 8'd100) : r_raw;
  assign qc      = r_ge ? 8'(q_r + 8'd1) : q_r;

  // gregorian leap year and calendar checks
  assign leap     = (year_r[1:0] == 2'b00) && ((rem != 8'd0) || (qc[1:0] == 2'b00));
  assign month_ok = (month_r >= 7'd1) && (month_r <= 7'd12);
  assign len      = dfl_pkg::month_len(month_r[3:0], leap);
  assign day_ok   = (day_r != 7'd0) && (day_r <= {2'b00, len});
  assign date_ok  = !year_r[14] && month_ok && day_ok;

  // first failing check sets the status
  always_comb begin
    if (!date_ok) begin
      pre_status = dfl_pkg::ST_BAD_DATE;
    end else if (op_r == dfl_pkg::OP_QUERY && amount_r[27]) begin
      pre_status = dfl_pkg::ST_NEGATIVE;
    end else if (op_r == dfl_pkg::OP_QUERY && amount_r[26:0] > amount_limit_r) begin
      pre_status = dfl_pkg::ST_TOO_LARGE;
    end else begin
      pre_status = dfl_pkg::ST_OK;
    end
  end

  // command toward the queue
  assign push                = (state_r == F_EVAL) && !q_full;
  assign push_cmd.op         = dfl_pkg::opcode_t'(op_r);
  assign push_cmd.pre_status = pre_status;
  assign push_cmd.date       = {year_r[13:0], month_r[3:0], day_r[4:0]};
  assign push_cmd.amount     = amount_r[26:0];
  assign push_cmd.rate       = rate_r;

  // amount limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_limit_r <= dfl_pkg::AMOUNT_LIMIT_RESET;
    end else if (cfg_valid) begin
      amount_limit_r <= cfg_data;
    end
  end

  // front sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            op_r     <= in_opcode;
            year_r   <= in_year;
            month_r  <= in_month;
            day_r    <= in_day;
            amount_r <= in_amount;
            rate_r   <= in_entry_rate;
            state_r  <= F_DIV;
          end
        end
        F_DIV: begin
          q_r     <= q_prod[23:16];
          state_r <= F_EVAL;
        end
        F_EVAL: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- design/dfl_queue.sv -----
`timescale 1ns / 1ps
// short command queue between front and back
module dfl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dfl_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output dfl_pkg::cmd_t  pop_cmd,
  output logic           empty
);

  dfl_pkg::cmd_t                entries [dfl_pkg::QUEUE_DEPTH];
  logic [dfl_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [dfl_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [dfl_pkg::QCNT_W-1:0]   count_r;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count_r == dfl_pkg::QCNT_W'(dfl_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr_r];

  // pointer wrap
  function automatic logic [dfl_pkg::QPTR_W-1:0] bump(input logic [dfl_pkg::QPTR_W-1:0] p);
    logic [dfl_pkg::QPTR_W-1:0] n;
    if (p == dfl_pkg::QPTR_W'(dfl_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = dfl_pkg::QPTR_W'(p + 1'b1);
    end
    return n;
  endfunction

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= dfl_pkg::QCNT_W'(count_r + 1'b1);
      end else if (do_pop && !do_push) begin
        count_r <= dfl_pkg::QCNT_W'(count_r - 1'b1);
      end
    end
  end

endmodule

// ----- design/dfl_back.sv -----
`timescale 1ns / 1ps
// back end: table append, floor search over the table ram and rate multiply
module dfl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  dfl_pkg::cmd_t                 q_cmd,
  output logic                          pop,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [dfl_pkg::RATE_W-1:0]    out_rate_used,
  output logic [dfl_pkg::PROD_W-1:0]    out_product
);

  localparam int CW = dfl_pkg::CNT_W;
  localparam int AW = dfl_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CMP,
    S_FINISH,
    S_MUL_LO,
    S_MUL_HI,
    S_DONE
  } bstate_t;

  bstate_t                          state_r;
  dfl_pkg::cmd_t                    cmd_r;
  logic [CW-1:0]                    count_r;
  logic                             sorted_r;
  logic [dfl_pkg::DATE_W-1:0]       last_date_r;
  logic                             mode_bin_r;
  logic [CW-1:0]                    lo_r;
  logic [CW-1:0]                    hi_r;
  logic [CW-1:0]                    mid_r;
  logic [CW-1:0]                    idx_r;
  logic                             below_seen_r;
  logic                             at_seen_r;
  logic                             at_eq_r;
  logic [dfl_pkg::RATE_W-1:0]       below_rate_r;
  logic [dfl_pkg::RATE_W-1:0]       at_rate_r;
  logic [dfl_pkg::RATE_W-1:0]       rate_sel_r;
  logic [42:0]                      plo_r;
  logic [50:0]                      phi_r;
  logic                             out_valid_r;
  dfl_pkg::status_t                 out_status_r;
  logic [dfl_pkg::RATE_W-1:0]       out_rate_r;
  logic [dfl_pkg::PROD_W-1:0]       out_product_r;

  logic [CW:0]                      mid_sum;
  logic [CW-1:0]                    mid;
  logic [AW-1:0]                    raddr;
  logic                             table_full;
  logic                             load_ok;
  logic [dfl_pkg::DATE_W-1:0]       rd_date;
  logic [dfl_pkg::RATE_W-1:0]       rd_rate;
  logic                             e_less;
  logic                             e_eq;
  logic [CW-1:0]                    lo_nxt;
  logic [CW-1:0]                    hi_nxt;
  logic [CW-1:0]                    idx_nxt;
  logic [42:0]                      plo;
  logic [50:0]                      phi;
  logic [dfl_pkg::PROD_W-1:0]       prod_sum;

  assign pop = (state_r == S_IDLE) && !q_empty;

  // search address: midpoint for binary search, running index for a scan
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CW:1];
  assign raddr   = mode_bin_r ? mid[AW-1:0] : idx_r[AW-1:0];

  // append goes to the slot after the last entry
  assign table_full = (count_r >= CW'(dfl_pkg::TABLE_DEPTH));
  assign load_ok    = (state_r == S_DISPATCH) && (cmd_r.op == dfl_pkg::OP_LOAD) &&
                      (cmd_r.pre_status == dfl_pkg::ST_OK) && !table_full;

  dfl_ram #(
    .WIDTH (dfl_pkg::DATE_W),
    .DEPTH (dfl_pkg::TABLE_DEPTH)
  ) u_date_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (count_r[AW-1:0]),
    .wdata (cmd_r.date),
    .raddr (raddr),
    .rdata (rd_date)
  );

  dfl_ram #(
    .WIDTH (dfl_pkg::RATE_W),
    .DEPTH (dfl_pkg::TABLE_DEPTH)
  ) u_rate_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (count_r[AW-1:0]),
    .wdata (cmd_r.rate),
    .raddr (raddr),
    .rdata (rd_rate)
  );

  // compare of the entry just read
  assign e_less  = (rd_date < cmd_r.date);
  assign e_eq    = (rd_date == cmd_r.date);
  assign lo_nxt  = e_less ? CW'(mid_r + 1'b1) : lo_r;
  assign hi_nxt  = e_less ? hi_r : mid_r;
  assign idx_nxt = CW'(idx_r + 1'b1);

  // rate split into a low 16-bit and a high 24-bit part, one product per cycle
  assign plo      = 43'(cmd_r.amount) * 43'(rate_sel_r[15:0]);
  assign phi      = 51'(cmd_r.amount) * 51'(rate_sel_r[39:16]);
  assign prod_sum = dfl_pkg::PROD_W'(phi_r + 51'(plo_r[42:16]));

  // back sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sorted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_cmd;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          below_seen_r <= 1'b0;
          at_seen_r    <= 1'b0;
          at_eq_r      <= 1'b0;
          lo_r         <= '0;
          hi_r         <= count_r;
          idx_r        <= '0;
          mode_bin_r   <= sorted_r;
          if (cmd_r.pre_status != dfl_pkg::ST_OK) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= cmd_r.pre_status;
            out_rate_r    <= '0;
            out_product_r <= '0;
            state_r       <= S_IDLE;
          end else if (cmd_r.op == dfl_pkg::OP_LOAD) begin
            out_valid_r   <= 1'b1;
            out_rate_r    <= '0;
            out_product_r <= '0;
            state_r       <= S_IDLE;
            if (table_full) begin
              out_status_r <= dfl_pkg::ST_FULL;
            end else begin
              out_status_r <= dfl_pkg::ST_OK;
              count_r      <= CW'(count_r + 1'b1);
              last_date_r  <= cmd_r.date;
              if (count_r != '0 && cmd_r.date < last_date_r) begin
                sorted_r <= 1'b0;
              end
            end
          end else if (count_r == '0) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= dfl_pkg::ST_NO_DATA;
            out_rate_r    <= '0;
            out_product_r <= '0;
            state_r       <= S_IDLE;
          end else begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          mid_r   <= mid;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (mode_bin_r) begin
            // lower bound step; remember neighbors on both sides
            lo_r <= lo_nxt;
            hi_r <= hi_nxt;
            if (e_less) begin
              below_seen_r <= 1'b1;
              below_rate_r <= rd_rate;
            end else begin
              at_seen_r <= 1'b1;
              at_eq_r   <= e_eq;
              at_rate_r <= rd_rate;
            end
            state_r <= (lo_nxt == hi_nxt) ? S_FINISH : S_READ;
          end else begin
            // scan in load order until a match or a later entry
            if (e_eq) begin
              at_seen_r <= 1'b1;
              at_eq_r   <= 1'b1;
              at_rate_r <= rd_rate;
              state_r   <= S_FINISH;
            end else if (e_less) begin
              below_seen_r <= 1'b1;
              below_rate_r <= rd_rate;
              idx_r        <= idx_nxt;
              state_r      <= (idx_nxt == count_r) ? S_FINISH : S_READ;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (at_seen_r && at_eq_r) begin
            rate_sel_r <= at_rate_r;
            state_r    <= S_MUL_LO;
          end else if (below_seen_r) begin
            rate_sel_r <= below_rate_r;
            state_r    <= S_MUL_LO;
          end else begin
            out_valid_r   <= 1'b1;
            out_status_r  <= dfl_pkg::ST_NO_DATA;
            out_rate_r    <= '0;
            out_product_r <= '0;
            state_r       <= S_IDLE;
          end
        end
        S_MUL_LO: begin
          plo_r   <= plo;
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi_r   <= phi;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= dfl_pkg::ST_OK;
          out_rate_r    <= rate_sel_r;
          out_product_r <= prod_sum;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_rate_used = out_rate_r;
  assign out_product   = out_product_r;

  // result strobe is never held high
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  // fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(dfl_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // binary search interval is never empty when a read is issued
  a_search_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && mode_bin_r) |-> (lo_r < hi_r))
    else $error("search read with empty interval");

  // failed items carry zero rate and product
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != dfl_pkg::ST_OK) |->
      (out_rate_r == '0 && out_product_r == '0))
    else $error("nonzero payload on failed item");

endmodule

// ----- design/dated_rate_floor_lookup.sv -----
`timescale 1ns / 1ps
// top level of the dated rate floor lookup
//
//  channel  | ports                                    | handshake
//  ---------+------------------------------------------+-------------------------------
//  input    | in_opcode in_year in_month in_day        | taken when start && !busy
//           | in_amount in_entry_rate                  |
//  result   | out_status out_rate_used out_product     | out_valid for one cycle
//  config   | cfg_data                                 | written when cfg_valid && cfg_ready
//
//  the front steps through capture, divide year by 100 and classify for each item, and
//  waits in classify while the queue is full; the back answers a load or a failed check
//  from its dispatch state, and for a query on a table loaded in date order runs ram read
//  and compare steps of a binary search, then finish, low multiply, high multiply and done;
//  once an entry is loaded out of date order a query scans from the start, entry by entry
//  busy is high while the front works on an item; the two entry command queue lets the
//  front take new items while the back searches, and busy stays high once it is full
//  reset clears the entry count and the queue and restores the amount limit; the table rams are not cleared
//  results cannot be held off by the receiver
module dated_rate_floor_lookup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic signed [14:0]            in_year,
  input  logic [6:0]                    in_month,
  input  logic [6:0]                    in_day,
  input  logic signed [27:0]            in_amount,
  input  logic [39:0]                   in_entry_rate,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [39:0]                   out_rate_used,
  output logic [50:0]                   out_product,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [26:0]                   cfg_data
);

  logic           push;
  dfl_pkg::cmd_t  push_cmd;
  logic           q_full;
  logic           pop;
  dfl_pkg::cmd_t  pop_cmd;
  logic           q_empty;

  // the limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // classify items
  dfl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .in_amount     (in_amount),
    .in_entry_rate (in_entry_rate),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  // command queue
  dfl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // table, search and multiply
  dfl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (pop_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_rate_used (out_rate_used),
    .out_product   (out_product)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the dated rate floor lookup: directed and random items
module testbench;
  import dfl_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [14:0] YEAR_MIN = -15'sd9999;

  typedef struct {
    status_t           status;
    logic [RATE_W-1:0] rate;
    logic [PROD_W-1:0] prod;
  } lookup_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_opcode = 1'b0;
  logic signed [14:0]  in_year = '0;
  logic [6:0]          in_month = '0;
  logic [6:0]          in_day = '0;
  logic signed [27:0]  in_amount = '0;
  logic [39:0]         in_entry_rate = '0;
  logic                out_valid;
  logic [2:0]          out_status;
  logic [39:0]         out_rate_used;
  logic [50:0]         out_product;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [26:0]         cfg_data = '0;

  dated_rate_floor_lookup dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .in_amount     (in_amount),
    .in_entry_rate (in_entry_rate),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_rate_used (out_rate_used),
    .out_product   (out_product),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // predictor copy of the rate table and the amount limit
  logic [DATE_W-1:0]  tbl_date [TABLE_DEPTH];
  logic [RATE_W-1:0]  tbl_rate [TABLE_DEPTH];
  int                 tbl_fill = 0;
  logic [LIMIT_W-1:0] limit_q16 = AMOUNT_LIMIT_RESET;
  lookup_result_t     pending_results[$];

  int error_count = 0;
  int result_count = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  int burst_left = 0;
  bit start_sched = 1'b0;

  always #5 clk = ~clk;

  // one line per mismatch
  task automatic log_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      log_error("timeout waiting for results");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // compare each result with the oldest pending prediction
  always @(posedge clk) begin : check_result
    lookup_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        log_error($sformatf("result %0d arrived with nothing pending", result_count));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status)
          log_error($sformatf("result %0d status %0d, want %0d", result_count, out_status,
                              exp_r.status));
        if (out_rate_used !== exp_r.rate)
          log_error($sformatf("result %0d rate %h, want %h", result_count, out_rate_used,
                              exp_r.rate));
        if (out_product !== exp_r.prod)
          log_error($sformatf("result %0d product %h, want %h", result_count, out_product,
                              exp_r.prod));
      end
      result_count++;
    end
  end

  // gregorian month length
  function automatic int days_in_month(input int y, input int m);
    bit leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      2: begin
        return leap ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // calendar check and packing into year, month, day bit fields
  function automatic bit pack_calendar(input logic [14:0] y, input logic [6:0] m,
                                       input logic [6:0] d, output logic [DATE_W-1:0] pd);
    int mv, dv;
    mv = m;
    dv = d;
    pd = '0;
    if (y[14]) return 1'b0;
    if (mv < 1 || mv > 12) return 1'b0;
    if (dv < 1 || dv > days_in_month(y[13:0], mv)) return 1'b0;
    pd = {y[13:0], m[3:0], d[4:0]};
    return 1'b1;
  endfunction

  // expected result of one accepted item, updating the predictor table
  task automatic predict_lookup(input opcode_t op, input logic [14:0] y, input logic [6:0] m,
                                input logic [6:0] d, input logic [27:0] amt,
                                input logic [39:0] rate);
    lookup_result_t    res;
    logic [DATE_W-1:0] pd;
    logic [RATE_W-1:0] best;
    logic [66:0]       wide;
    bit                ok;
    bit                found;
    res.status = ST_OK;
    res.rate = '0;
    res.prod = '0;
    best = '0;
    found = 1'b0;
    ok = pack_calendar(y, m, d, pd);
    if (op == OP_LOAD) begin
      if (!ok) res.status = ST_BAD_DATE;
      else if (tbl_fill >= TABLE_DEPTH) res.status = ST_FULL;
      else begin
        tbl_date[tbl_fill] = pd;
        tbl_rate[tbl_fill] = rate;
        tbl_fill++;
      end
    end else if (!ok) begin
      res.status = ST_BAD_DATE;
    end else if (amt[27]) begin
      res.status = ST_NEGATIVE;
    end else if (amt[26:0] > limit_q16) begin
      res.status = ST_TOO_LARGE;
    end else begin
      // scan in load order: first equal entry wins, stop at the first later one
      for (int i = 0; i < tbl_fill; i++) begin
        if (tbl_date[i] == pd) begin
          found = 1'b1;
          best = tbl_rate[i];
          break;
        end
        if (tbl_date[i] > pd) break;
        found = 1'b1;
        best = tbl_rate[i];
      end
      if (!found) res.status = ST_NO_DATA;
      else begin
        res.rate = best;
        wide = 67'(amt[26:0]) * 67'(best);
        res.prod = wide[66:16];
      end
    end
    pending_results.insert(pending_results.size(), res);
  endtask

  // schedule start only when its value changes
  task automatic set_start(input bit v);
    if (v != start_sched) begin
      start <= v;
      start_sched = v;
    end
  endtask

  // send one item, with bursts and random gaps
  task automatic send_item(input opcode_t op, input logic [14:0] y, input logic [6:0] m,
                           input logic [6:0] d, input logic [27:0] amt,
                           input logic [39:0] rate);
    int gap;
    gap = 0;
    if (idle_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(12, 1);
        gap = $urandom_range(9, 0);
      end
      burst_left--;
    end
    if (gap > 0) begin
      set_start(1'b0);
      repeat (gap) @(posedge clk);
    end
    set_start(1'b1);
    in_opcode <= op;
    in_year <= y;
    in_month <= m;
    in_day <= d;
    in_amount <= amt;
    in_entry_rate <= rate;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_lookup(op, y, m, d, amt, rate);
  endtask

  // hold the sender until every pending result has come
  task automatic drain_results();
    set_start(1'b0);
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_amount_limit(input logic [26:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_q16 = value;
  endtask

  // random valid date, leaning toward month ends and firsts
  task automatic rand_date(input int ylo, input int yhi, output logic [14:0] y,
                           output logic [6:0] m, output logic [6:0] d);
    int yv, mv, len, pick;
    yv = $urandom_range(yhi, ylo);
    mv = $urandom_range(12, 1);
    len = days_in_month(yv, mv);
    pick = $urandom_range(9, 0);
    y = 15'(yv);
    m = 7'(mv);
    if (pick < 2) d = 7'(len);
    else if (pick < 3) d = 7'd1;
    else d = 7'($urandom_range(len, 1));
  endtask

  task automatic unpack_entry(input int idx, output logic [14:0] y, output logic [6:0] m,
                              output logic [6:0] d);
    y = {1'b0, tbl_date[idx][22:9]};
    m = {3'b0, tbl_date[idx][8:5]};
    d = {2'b0, tbl_date[idx][4:0]};
  endtask

  // query amount: mostly in range, some negative, some over the limit
  function automatic logic [27:0] rand_amount();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 8) return {1'b1, 27'($urandom)};
    if (pick < 16 && limit_q16 != LIMIT_MAX)
      return {1'b0, 27'($urandom_range(LIMIT_MAX, limit_q16 + 1))};
    if (pick < 22) return {1'b0, limit_q16};
    if (pick < 26) return '0;
    return {1'b0, 27'($urandom_range(limit_q16, 0))};
  endfunction

  function automatic logic [39:0] rand_rate();
    logic [63:0] w;
    int pick;
    pick = $urandom_range(99, 0);
    w = {$urandom, $urandom};
    if (pick < 5) return '0;
    if (pick < 10) return RATE_MAX;
    return w[39:0];
  endfunction

  // well-formed query: an exact table date or a random date in a year span
  task automatic send_query_near(input int ylo, input int yhi);
    logic [14:0] y;
    logic [6:0]  m, d;
    if (tbl_fill > 0 && $urandom_range(9, 0) < 4) unpack_entry($urandom_range(tbl_fill - 1, 0),
                                                               y, m, d);
    else rand_date(ylo, yhi, y, m, d);
    send_item(OP_QUERY, y, m, d, rand_amount(), rand_rate());
  endtask

  // raw random fields; loads can be forced to a bad date to keep the table in order
  task automatic send_noise(input bit keep_sorted);
    opcode_t           op;
    logic [14:0]       y;
    logic [6:0]        m, d;
    logic [DATE_W-1:0] pd;
    op = opcode_t'($urandom_range(1, 0));
    y = 15'($urandom);
    m = 7'($urandom);
    d = 7'($urandom);
    if (keep_sorted && op == OP_LOAD && pack_calendar(y, m, d, pd))
      m = 7'($urandom_range(127, 13));
    send_item(op, y, m, d, 28'($urandom), rand_rate());
  endtask

  // load at or after the latest entry, now and then repeating its date
  task automatic send_sorted_load();
    logic [14:0]       y;
    logic [6:0]        m, d;
    logic [DATE_W-1:0] pd;
    int                ylast;
    ylast = tbl_date[tbl_fill - 1][22:9];
    if ($urandom_range(19, 0) == 0) begin
      unpack_entry(tbl_fill - 1, y, m, d);
    end else begin
      do begin
        rand_date(ylast, ylast + 1, y, m, d);
        void'(pack_calendar(y, m, d, pd));
      end while (pd <= tbl_date[tbl_fill - 1]);
    end
    send_item(OP_LOAD, y, m, d, 28'($urandom), rand_rate());
  endtask

  // calendar checks, check order, exact and floor hits at the reset limit
  task automatic test_directed_checks();
    idle_on = 1'b1;
    // empty table
    send_item(OP_QUERY, 15'd2000, 7'd1, 7'd1, 28'd1, '0);
    // year 0 is a leap year
    send_item(OP_LOAD, 15'd0, 7'd2, 7'd29, 28'hFFFFFFF, RATE_MAX);
    // century years, one not divisible by 400 and one divisible by 400
    send_item(OP_LOAD, 15'd1900, 7'd2, 7'd29, '0, 40'd1);
    send_item(OP_LOAD, 15'd2000, 7'd2, 7'd29, '0, 40'h10000);
    // negative years
    send_item(OP_LOAD, 15'h7FFF, 7'd1, 7'd1, '0, RATE_MAX);
    send_item(OP_LOAD, YEAR_MIN, 7'd12, 7'd31, '0, RATE_MAX);
    // month and day out of range, then a valid leap day load
    send_item(OP_LOAD, 15'd2001, 7'd0, 7'd5, '0, 40'd7);
    send_item(OP_LOAD, 15'd2001, 7'd13, 7'd5, '0, 40'd7);
    send_item(OP_LOAD, 15'd2001, 7'd4, 7'd31, '0, 40'd7);
    send_item(OP_LOAD, 15'd2001, 7'd4, 7'd0, '0, 40'd7);
    send_item(OP_LOAD, 15'd2003, 7'd2, 7'd29, '0, 40'd7);
    send_item(OP_LOAD, 15'd2004, 7'd2, 7'd29, 28'h8000000, 40'h18000);
    // exact match with the amount at the limit
    send_item(OP_QUERY, 15'd2000, 7'd2, 7'd29, {1'b0, AMOUNT_LIMIT_RESET}, '0);
    // floor to the earliest entry
    send_item(OP_QUERY, 15'd2000, 7'd2, 7'd28, 28'd1, RATE_MAX);
    // before the first entry
    send_item(OP_QUERY, 15'd0, 7'd1, 7'd31, 28'd5, '0);
    // bad date wins over a negative amount
    send_item(OP_QUERY, 15'd2001, 7'd99, 7'd99, 28'hFFFFFFF, '0);
    send_item(OP_QUERY, 15'd2001, 7'd1, 7'd1, 28'hFFFFFFF, '0);
    // most negative amount, then amounts over the limit and late dates
    send_item(OP_QUERY, 15'd2001, 7'd1, 7'd1, 28'h8000000, '0);
    send_item(OP_QUERY, 15'd2001, 7'd12, 7'd31, {1'b0, AMOUNT_LIMIT_RESET + 27'd1}, '0);
    send_item(OP_QUERY, 15'd2001, 7'd1, 7'd1, 28'h7FFFFFF, '0);
    send_item(OP_QUERY, 15'd9999, 7'd12, 7'd31, 28'd0, '0);
    send_item(OP_QUERY, 15'h3FFF, 7'd12, 7'd31, 28'd3, '0);
    send_item(OP_QUERY, 15'd2004, 7'd3, 7'd1, 28'h0FFFFFF, '0);
  endtask

  // limit at zero, at its maximum and at a random value
  task automatic test_amount_limit();
    drain_results();
    write_amount_limit('0);
    send_item(OP_QUERY, 15'd2000, 7'd3, 7'd1, 28'd0, '0);
    send_item(OP_QUERY, 15'd2000, 7'd3, 7'd1, 28'd1, '0);
    drain_results();
    write_amount_limit(LIMIT_MAX);
    // largest amount against the largest rate, then against the rate of the 2000 entry
    send_item(OP_QUERY, 15'd0, 7'd12, 7'd31, 28'h7FFFFFF, '0);
    send_item(OP_QUERY, 15'd2000, 7'd2, 7'd29, 28'h7FFFFFF, '0);
    drain_results();
    write_amount_limit(27'($urandom));
    repeat (6) send_query_near(1995, 2010);
  endtask

  // table kept in date order, several limits, one round with no sender gaps
  task automatic test_sorted_lookup();
    int pick;
    for (int round = 0; round < 4; round++) begin
      drain_results();
      case (round)
        0: write_amount_limit(27'($urandom));
        1: write_amount_limit(LIMIT_MAX);
        2: write_amount_limit(27'($urandom_range(262144, 0)));
        default: write_amount_limit(AMOUNT_LIMIT_RESET);
      endcase
      idle_on = (round != 1);
      repeat (350) begin
        pick = $urandom_range(99, 0);
        if (pick < 15) send_sorted_load();
        else if (pick < 27) send_noise(1'b1);
        else send_query_near(1995, tbl_date[tbl_fill - 1][22:9] + 1);
        if ($urandom_range(199, 0) == 0) drain_results();
      end
    end
  endtask

  // entries loaded out of date order
  task automatic test_unsorted_scan();
    logic [14:0] y;
    logic [6:0]  m, d;
    int          pick;
    drain_results();
    write_amount_limit(27'($urandom_range(LIMIT_MAX, 27'h100000)));
    idle_on = 1'b1;
    // an older entry after newer ones
    send_item(OP_LOAD, 15'd1000, 7'd6, 7'd15, '0, rand_rate());
    // a second entry on the date of an existing one; the first one stays in use
    unpack_entry(1, y, m, d);
    send_item(OP_LOAD, y, m, d, '0, rand_rate());
    send_item(OP_QUERY, y, m, d, 28'd65536, '0);
    send_item(OP_QUERY, 15'd1000, 7'd6, 7'd15, 28'd65536, '0);
    repeat (300) begin
      pick = $urandom_range(99, 0);
      if (pick < 20) begin
        rand_date(0, 16383, y, m, d);
        send_item(OP_LOAD, y, m, d, 28'($urandom), rand_rate());
      end else if (pick < 30) begin
        send_noise(1'b0);
      end else begin
        send_query_near(0, 16383);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_checks();
    test_amount_limit();
    test_sorted_lookup();
    test_unsorted_scan();
    drain_results();
    repeat (64) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/dfl_pkg.sv
design/dfl_ram.sv
design/dfl_front.sv
design/dfl_queue.sv
design/dfl_back.sv
design/dated_rate_floor_lookup.sv
tb/testbench.sv
